FILE: design/quadruple_code_executor_core_defines.svh
// Assertion macros shared by the executor design files.
`ifndef QUADRUPLE_CODE_EXECUTOR_CORE_DEFINES_SVH
`define QUADRUPLE_CODE_EXECUTOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define QCE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define QCE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define QCE_ASSERT(lbl, clk, rstn, prop, msg)
`define QCE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: design/qce_pkg.sv
// ----------------------------------------------------------------------------
// qce_pkg
// Types, opcodes and defaults shared by the quadruple code executor.
// ----------------------------------------------------------------------------
`default_nettype none
package qce_pkg;
  localparam int MemDepthDef   = 1024;
  localparam int ProgDepthDef  = 1024;
  localparam int LabelCountDef = 256;

  typedef enum logic [3:0] {
    OP_MOVE = 4'd0, OP_ADD = 4'd1, OP_SUB = 4'd2, OP_MULT = 4'd3, OP_DIV = 4'd4,
    OP_GT = 4'd5, OP_LT = 4'd6, OP_GE = 4'd7, OP_LE = 4'd8, OP_EQ = 4'd9,
    OP_NE = 4'd10, OP_READ = 4'd11, OP_WRITE = 4'd12, OP_JMP = 4'd13,
    OP_JZ = 4'd14, OP_NOP = 4'd15
  } opcode_t;

  localparam logic [1:0] MODE_RAM   = 2'd1;
  localparam logic [1:0] MODE_CACHE = 2'd2;

  typedef struct packed {
    logic        action;
    logic [3:0]  opcode;
    logic [9:0]  pc;
    logic [1:0]  first_mode;
    logic [31:0] first_value;
    logic [1:0]  second_mode;
    logic [31:0] second_value;
    logic [1:0]  dest_mode;
    logic [9:0]  dest_index;
    logic [7:0]  label;
    logic [31:0] read_value;
  } item_t;

  typedef struct packed {
    logic [10:0] next_pc;
    logic        out_valid;
    logic [31:0] out_value;
    logic        div_zero;
  } result_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // capture item
    logic clr_step;  // clearing pass write
    logic rd_a;      // issue operand a read
    logic rd_b;      // issue operand b read
    logic cap_a;     // latch operand a
    logic cap_b;     // latch operand b
    logic mul_go;    // register product
    logic div_start;
    logic commit;    // write stores, build result
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic div_done;
    logic is_div;
  } stat_t;
endpackage
`default_nettype wire

FILE: design/qce_if.sv
// ----------------------------------------------------------------------------
// qce_in_if / qce_out_if
// Valid/ready channels that carry one item or one result per beat.
// ----------------------------------------------------------------------------
`default_nettype none
interface qce_in_if;
  logic           valid;
  logic           ready;
  qce_pkg::item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface qce_out_if;
  logic             valid;
  logic             ready;
  qce_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: design/quadruple_code_executor_core.sv
// Flow: read a, read b, latch b, execute, commit; div waits on the 32-step divider.
// One item at a time: a new item is taken only when idle and the result is free.
// Reset: synchronous active-low; a clearing pass over max(MEM_DEPTH, LABEL_COUNT)
// addresses zeroes the stores and label table while no item is taken.
// ----------------------------------------------------------------------------
// quadruple_code_executor_core
// Executes one decoded quadruple per beat and returns the next pc.
// ----------------------------------------------------------------------------
`default_nettype none
module quadruple_code_executor_core #(
  parameter int MEM_DEPTH   = qce_pkg::MemDepthDef,
  parameter int LABEL_COUNT = qce_pkg::LabelCountDef
) (
  input wire logic  clk,
  input wire logic  rst_n,
  qce_in_if.sink    in_ch,
  qce_out_if.source out_ch
);
  qce_pkg::cmd_t  cmd;
  qce_pkg::stat_t stat;

  qce_ctrl u_ctrl (
    .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .stat, .cmd
  );

  qce_datapath #(.MEM_DEPTH(MEM_DEPTH), .LABEL_COUNT(LABEL_COUNT)) u_dp (
    .clk, .rst_n, .item(in_ch.data), .cmd, .stat, .result(out_ch.data)
  );
endmodule
`default_nettype wire

FILE: design/qce_div.sv
// ----------------------------------------------------------------------------
// qce_div
// Radix-2 restoring signed divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module qce_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      quotient
);
  logic [31:0] rem_r, rem_nxt, quo_r, quo_nxt, den_r, den_nxt;
  logic        neg_r, neg_nxt, busy_r, busy_nxt, done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [32:0] trial;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[31]} - {1'b0, den_r};
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend[31] ? (32'd0 - dividend) : dividend;
      den_nxt  = divisor[31] ? (32'd0 - divisor) : divisor;
      neg_nxt  = dividend[31] ^ divisor[31];
      busy_nxt = 1'b1;
      cnt_nxt  = 6'd0;
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial[31:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[30:0], quo_r[31]};
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? (32'd0 - quo_r) : quo_r;
endmodule
`default_nettype wire

FILE: design/qce_datapath.sv
// ----------------------------------------------------------------------------
// qce_datapath
// Item register, data stores, label table, ALU, divider and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "quadruple_code_executor_core_defines.svh"
module qce_datapath #(
  parameter int MEM_DEPTH   = qce_pkg::MemDepthDef,
  parameter int LABEL_COUNT = qce_pkg::LabelCountDef
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire qce_pkg::item_t   item,
  input  wire qce_pkg::cmd_t    cmd,
  output qce_pkg::stat_t        stat,
  output qce_pkg::result_t      result
);
  localparam int AW = $clog2(MEM_DEPTH);
  localparam int LW = $clog2(LABEL_COUNT);
  localparam int CW = (AW > LW) ? AW : LW;

  qce_pkg::item_t  it_r;
  qce_pkg::result_t res_r, res_nxt;
  logic [31:0] ram_mem   [MEM_DEPTH];
  logic [31:0] cache_mem [MEM_DEPTH];
  // Each label entry holds a defined bit above the recorded pc.
  logic [10:0] lab_mem   [LABEL_COUNT];
  logic [CW:0] clr_r;
  logic [31:0] ram_q, cache_q, a_r, b_r, prod_r, quo, r;
  logic [10:0] lab_q;
  logic        lab_defq, sel_ram_r, sel_cache_r, div_done;
  logic [AW-1:0] rd_idx, didx;
  logic [LW-1:0] lidx;
  logic [1:0]  rd_mode;
  logic [31:0] rd_val;
  logic        store_en, div_go;
  logic signed [31:0] sa, sb;

  always_ff @(posedge clk) begin
    if (cmd.load) it_r <= item;
  end

  assign rd_mode = cmd.rd_b ? it_r.second_mode : it_r.first_mode;
  assign rd_val  = cmd.rd_b ? it_r.second_value : it_r.first_value;
  assign rd_idx  = rd_val[AW-1:0];
  assign didx    = AW'(it_r.dest_index);
  assign lidx    = LW'(it_r.label);

  // Reads are registered; the select of the mode is kept alongside.
  always_ff @(posedge clk) begin
    if (cmd.rd_a || cmd.rd_b) begin
      ram_q       <= ram_mem[rd_idx];
      cache_q     <= cache_mem[rd_idx];
      lab_q       <= lab_mem[lidx];
      sel_ram_r   <= (rd_mode == qce_pkg::MODE_RAM);
      sel_cache_r <= (rd_mode == qce_pkg::MODE_CACHE);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_a) a_r <= sel_ram_r ? ram_q : (sel_cache_r ? cache_q : it_r.first_value);
    if (cmd.cap_b) b_r <= sel_ram_r ? ram_q : (sel_cache_r ? cache_q : it_r.second_value);
    if (cmd.mul_go) prod_r <= a_r * b_r;
  end

  assign div_go = cmd.div_start;
  qce_div u_div (
    .clk, .rst_n, .start(div_go), .dividend(a_r), .divisor(b_r),
    .done(div_done), .quotient(quo)
  );

  assign sa = a_r;
  assign sb = b_r;
  assign lab_defq = lab_q[10];

  always_comb begin
    r        = '0;
    store_en = 1'b1;
    res_nxt  = '0;
    res_nxt.next_pc = {1'b0, it_r.pc} + 11'd1;
    unique case (qce_pkg::opcode_t'(it_r.opcode))
      qce_pkg::OP_MOVE:  r = a_r;
      qce_pkg::OP_ADD:   r = a_r + b_r;
      qce_pkg::OP_SUB:   r = a_r - b_r;
      qce_pkg::OP_MULT:  r = prod_r;
      qce_pkg::OP_DIV: begin
        r = (b_r == '0) ? '0 : quo;
        res_nxt.div_zero = (b_r == '0);
      end
      qce_pkg::OP_GT:    r = {31'd0, sa > sb};
      qce_pkg::OP_LT:    r = {31'd0, sa < sb};
      qce_pkg::OP_GE:    r = {31'd0, sa >= sb};
      qce_pkg::OP_LE:    r = {31'd0, sa <= sb};
      qce_pkg::OP_EQ:    r = {31'd0, sa == sb};
      qce_pkg::OP_NE:    r = {31'd0, sa != sb};
      qce_pkg::OP_READ:  store_en = 1'b0;
      qce_pkg::OP_WRITE: begin
        store_en = 1'b0;
        res_nxt.out_valid = 1'b1;
        res_nxt.out_value = a_r;
      end
      qce_pkg::OP_JMP: begin
        store_en = 1'b0;
        res_nxt.next_pc = {1'b0, lab_q[9:0]} + 11'd1;
      end
      qce_pkg::OP_JZ: begin
        store_en = 1'b0;
        if (a_r == '0) res_nxt.next_pc = {1'b0, lab_q[9:0]} + 11'd1;
      end
      default: store_en = 1'b0;
    endcase
    if (!it_r.action) begin
      store_en = 1'b0;
      res_nxt  = '0;
      res_nxt.next_pc = {1'b0, it_r.pc} + 11'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) res_r <= res_nxt;
    if (cmd.clr_step) begin
      ram_mem[clr_r[AW-1:0]]   <= '0;
      cache_mem[clr_r[AW-1:0]] <= '0;
    end else if (cmd.commit && it_r.action) begin
      if (qce_pkg::opcode_t'(it_r.opcode) == qce_pkg::OP_READ) ram_mem[didx] <= it_r.read_value;
      else if (store_en && it_r.dest_mode == qce_pkg::MODE_RAM) ram_mem[didx] <= r;
      else if (store_en && it_r.dest_mode == qce_pkg::MODE_CACHE) cache_mem[didx] <= r;
    end
    if (cmd.clr_step && clr_r < (CW+1)'(LABEL_COUNT)) lab_mem[clr_r[LW-1:0]] <= '0;
    else if (cmd.commit && !it_r.action && !lab_defq) lab_mem[lidx] <= {1'b1, it_r.pc};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else begin
      if (cmd.clr_step) clr_r <= clr_r + (CW+1)'(1);
    end
  end

  localparam int ClrLen = (MEM_DEPTH > LABEL_COUNT) ? MEM_DEPTH : LABEL_COUNT;
  assign stat.clr_done = (clr_r == (CW+1)'(ClrLen));
  assign stat.div_done = div_done;
  assign stat.is_div   = (qce_pkg::opcode_t'(it_r.opcode) == qce_pkg::OP_DIV);
  assign result = res_r;

  `QCE_ASSERT(a_dz_div, clk, rst_n, $rose(cmd.commit) |=> (!res_r.div_zero || it_r.opcode == qce_pkg::OP_DIV), "div_zero on non-divide")
  `QCE_ASSERT(a_ov_write, clk, rst_n, cmd.commit |=> (res_r.out_valid == (it_r.action && it_r.opcode == qce_pkg::OP_WRITE)), "out_valid mismatch")
  `QCE_ASSERT(a_clr_bound, clk, rst_n, cmd.clr_step |-> !stat.clr_done, "clear past end")
endmodule
`default_nettype wire

FILE: design/qce_ctrl.sv
// ----------------------------------------------------------------------------
// qce_ctrl
// Sequencer: clearing pass, operand reads, execute, result handoff.
// ----------------------------------------------------------------------------
`default_nettype none
`include "quadruple_code_executor_core_defines.svh"
module qce_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire qce_pkg::stat_t stat,
  output qce_pkg::cmd_t       cmd
);
  typedef enum logic [8:0] {
    S_CLR  = 9'b000000001, S_IDLE = 9'b000000010, S_RDA  = 9'b000000100,
    S_RDB  = 9'b000001000, S_CAPA = 9'b000010000, S_CAPB = 9'b000100000,
    S_OP   = 9'b001000000, S_DIV  = 9'b010000000, S_DONE = 9'b100000000
  } state_t;
  state_t state_r, state_nxt;
  logic   ov_r, ov_nxt;

  always_comb begin
    state_nxt = state_r;
    ov_nxt    = ov_r;
    cmd       = '0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (state_r)
      S_CLR: begin
        if (stat.clr_done) state_nxt = S_IDLE;
        else cmd.clr_step = 1'b1;
      end
      S_IDLE: if (in_valid && (!ov_r || out_ready)) begin
        cmd.load  = 1'b1;
        state_nxt = S_RDA;
      end
      S_RDA: begin
        cmd.rd_a  = 1'b1;
        state_nxt = S_RDB;
      end
      S_RDB: begin
        cmd.rd_b  = 1'b1;
        cmd.cap_a = 1'b1;
        state_nxt = S_CAPB;
      end
      S_CAPA: state_nxt = S_CAPB;
      S_CAPB: begin
        cmd.cap_b = 1'b1;
        state_nxt = S_OP;
      end
      S_OP: begin
        cmd.mul_go = 1'b1;
        if (stat.is_div) begin
          cmd.div_start = 1'b1;
          state_nxt = S_DIV;
        end else state_nxt = S_DONE;
      end
      S_DIV: if (stat.div_done) state_nxt = S_DONE;
      S_DONE: begin
        cmd.commit = 1'b1;
        ov_nxt     = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE) && (!ov_r || out_ready);
  assign out_valid = ov_r;

  `QCE_ASSERT(a_onehot, clk, rst_n, $onehot(state_r), "state not one-hot")
  `QCE_ASSERT(a_commit_free, clk, rst_n, cmd.commit |-> (!ov_r || out_ready), "result overwritten")
  `QCE_ASSERT(a_no_take_clr, clk, rst_n, (state_r == S_CLR) |-> !in_ready, "item taken while clearing")
endmodule
`default_nettype wire
